@@ rtl/sss_pkg.sv @@
package sss_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SORT   = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [31:0]  operand_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]   status;
        logic [3:0]   position;
        logic [31:0]  entry_value;
        logic         last;
    } t_out_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SORT_RD,
        BK_SORT_WR,
        BK_SRCH_RD,
        BK_SRCH_CMP,
        BK_DUMP_RD,
        BK_DUMP_EMIT,
        BK_EMIT
    } t_bk_state;

endpackage

@@ rtl/sss_cmd_queue.sv @@
module sss_cmd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sss_pkg::t_in_item     i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output sss_pkg::t_in_item     o_item
);

    sss_pkg::t_in_item r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3)) else $error("queue count out of range");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("pop did not decrement");
    a_push_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("push did not increment");

endmodule

@@ rtl/sss_engine.sv @@
module sss_engine #(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_array_length,
    input  logic                  i_cmd_valid,
    input  sss_pkg::t_in_item     i_cmd,
    output logic                  o_cmd_take,
    input  logic                  i_out_busy,
    output logic                  o_out_valid,
    output sss_pkg::t_out_item    o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_mem [DEPTH];

    sss_pkg::t_bk_state r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_j;
    logic [CW-1:0]      r_pass;
    logic signed [CW:0] r_lo, r_hi;
    logic [AW-1:0]      r_mid;
    logic signed [31:0] r_key;
    logic signed [31:0] r_a, r_b;
    sss_pkg::t_out_item r_res;

    // second write for the swap goes to j+1 the cycle after
    logic               r_swap2;
    logic [AW-1:0]      r_swap_a;
    logic signed [31:0] r_swap_d;

    logic [CW-1:0]      cap;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [31:0] mem_wd;
    logic [AW-1:0]      ra_a, ra_b;
    logic signed [CW:0] mid_next;
    logic signed [CW:0] lo_n, hi_n;

    always_comb begin
        if (32'(i_array_length) >= 32'(DEPTH)) begin
            cap = CW'(DEPTH);
        end else begin
            cap = CW'(i_array_length);
        end
    end

    assign o_out_valid = (r_state == sss_pkg::BK_EMIT) || (r_state == sss_pkg::BK_DUMP_EMIT);
    assign o_out       = r_res;
    assign o_cmd_take  = (r_state == sss_pkg::BK_IDLE) && i_cmd_valid;

    // read ports: registered reads; writes from insert, swap low half, swap high half
    always_ff @(posedge i_clk) begin
        r_a <= r_mem[ra_a];
        r_b <= r_mem[ra_b];
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (r_swap2) begin
            r_mem[r_swap_a] <= r_swap_d;
        end
    end

    always_comb begin
        ra_a = r_j;
        ra_b = r_j + AW'(1);
        if (r_state == sss_pkg::BK_SRCH_RD || r_state == sss_pkg::BK_SRCH_CMP) begin
            ra_a = r_mid;
        end
    end

    // search step values
    always_comb begin
        lo_n = r_lo;
        hi_n = r_hi;
        if (r_key > r_a) begin
            lo_n = (CW+1)'(r_mid) + (CW+1)'(1);
        end else begin
            hi_n = (CW+1)'(r_mid) - (CW+1)'(1);
        end
        mid_next = (lo_n + hi_n) >>> 1;
        if ((lo_n + hi_n) < 0) begin
            mid_next = '0; // truncation toward zero of -1/2
        end
    end

    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        mem_wa  = r_j;
        mem_wd  = r_b;
        case (r_state)
            sss_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.cmd)
                        sss_pkg::CMD_INSERT: begin
                            n_state = sss_pkg::BK_EMIT;
                            if (r_count < cap) begin
                                mem_we = 1'b1;
                                mem_wa = r_count[AW-1:0];
                                mem_wd = i_cmd.operand_value;
                            end
                        end
                        sss_pkg::CMD_SORT: begin
                            n_state = (r_count < CW'(2)) ? sss_pkg::BK_EMIT
                                                         : sss_pkg::BK_SORT_RD;
                        end
                        sss_pkg::CMD_SEARCH: begin
                            n_state = (r_count == '0) ? sss_pkg::BK_EMIT
                                                      : sss_pkg::BK_SRCH_RD;
                        end
                        default: begin
                            n_state = (r_count == '0) ? sss_pkg::BK_EMIT
                                                      : sss_pkg::BK_DUMP_RD;
                        end
                    endcase
                end
            end
            sss_pkg::BK_SORT_RD: begin
                if (!r_swap2) begin
                    n_state = sss_pkg::BK_SORT_WR;
                end
            end
            sss_pkg::BK_SORT_WR: begin
                if (r_a > r_b) begin
                    mem_we = 1'b1;
                end
                n_state = sss_pkg::BK_SORT_RD;
                if (CW'(r_j) + CW'(2) >= r_count && r_pass + CW'(1) >= r_count) begin
                    n_state = sss_pkg::BK_EMIT;
                end
            end
            sss_pkg::BK_SRCH_RD: begin
                n_state = sss_pkg::BK_SRCH_CMP;
            end
            sss_pkg::BK_SRCH_CMP: begin
                if (r_a == r_key || r_lo > r_hi) begin
                    n_state = sss_pkg::BK_EMIT;
                end else if (mid_next < 0 || mid_next >= (CW+1)'(r_count)) begin
                    n_state = sss_pkg::BK_EMIT;
                end else begin
                    n_state = sss_pkg::BK_SRCH_RD;
                end
            end
            sss_pkg::BK_DUMP_RD: begin
                n_state = sss_pkg::BK_DUMP_EMIT;
            end
            sss_pkg::BK_DUMP_EMIT: begin
                if (!i_out_busy) begin
                    n_state = r_res.last ? sss_pkg::BK_IDLE : sss_pkg::BK_DUMP_RD;
                end
            end
            default: begin
                if (!i_out_busy) begin
                    n_state = sss_pkg::BK_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sss_pkg::BK_IDLE;
            r_count <= '0;
            r_swap2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_swap2 <= 1'b0;
            case (r_state)
                sss_pkg::BK_IDLE: begin
                    if (i_cmd_valid) begin
                        r_res.position    <= '0;
                        r_res.entry_value <= '0;
                        r_res.last        <= 1'b1;
                        r_key <= i_cmd.operand_value;
                        r_j <= '0;
                        r_pass <= CW'(1);
                        case (i_cmd.cmd)
                            sss_pkg::CMD_INSERT: begin
                                if (r_count < cap) begin
                                    r_count <= r_count + CW'(1);
                                    r_res.status <= sss_pkg::ST_OK;
                                end else begin
                                    r_res.status <= sss_pkg::ST_FULL;
                                end
                            end
                            sss_pkg::CMD_SORT: begin
                                r_res.status <= sss_pkg::ST_OK;
                            end
                            sss_pkg::CMD_SEARCH: begin
                                if (r_count == '0) begin
                                    r_res.status <= sss_pkg::ST_NOT_FOUND;
                                end else begin
                                    r_res.status <= sss_pkg::ST_OK;
                                    r_lo  <= '0;
                                    r_hi  <= (CW+1)'(r_count) - (CW+1)'(1);
                                    r_mid <= AW'((r_count - CW'(1)) >> 1);
                                end
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_res.status <= sss_pkg::ST_EMPTY;
                                end else begin
                                    r_res.status <= sss_pkg::ST_OK;
                                end
                            end
                        endcase
                    end
                end
                sss_pkg::BK_SORT_WR: begin
                    r_swap2  <= r_a > r_b;
                    r_swap_a <= r_j + AW'(1);
                    r_swap_d <= r_a;
                    if (CW'(r_j) + CW'(2) >= r_count) begin
                        r_j <= '0;
                        r_pass <= r_pass + CW'(1);
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                sss_pkg::BK_SRCH_CMP: begin
                    if (r_a == r_key || r_lo > r_hi) begin
                        if (r_lo <= r_hi) begin
                            r_res.position <= 4'(r_mid);
                        end else begin
                            r_res.status <= sss_pkg::ST_NOT_FOUND;
                        end
                    end else begin
                        r_lo <= lo_n;
                        r_hi <= hi_n;
                        if (mid_next < 0 || mid_next >= (CW+1)'(r_count)) begin
                            r_res.status <= sss_pkg::ST_NOT_FOUND;
                        end else begin
                            r_mid <= AW'(mid_next);
                        end
                    end
                end
                sss_pkg::BK_DUMP_RD: begin
                    r_res.status      <= sss_pkg::ST_OK;
                    r_res.position    <= 4'(r_j);
                    r_res.entry_value <= r_mem[r_j];
                    r_res.last        <= (CW'(r_j) + CW'(1) == r_count);
                end
                sss_pkg::BK_DUMP_EMIT: begin
                    if (!i_out_busy && !r_res.last) begin
                        r_j <= r_j + AW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("entry count beyond depth");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> (r_state != sss_pkg::BK_IDLE)) else $error("command lost");
    a_res_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sss_pkg::BK_EMIT) |-> r_res.last) else $error("single result not last");

endmodule

@@ rtl/sss_out_queue.sv @@
module sss_out_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sss_pkg::t_out_item    i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output sss_pkg::t_out_item    o_item
);

    sss_pkg::t_out_item r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("result queue count out of range");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("pop did not decrement");
    a_push_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("push did not increment");

endmodule

@@ rtl/sort_and_search_store.sv @@
// Sort runs (n-1)^2 compare-swap steps over the n stored entries, a swap adding a write of the
// upper entry; search probes by binary search; dump emits the entries in order, each held until
// the result queue has room. One command in the engine at a time; two-entry command and result
// queues decouple the ports. Synchronous active-low reset empties both queues, clears the entry
// count and sets array_length to 16; store is not cleared.
module sort_and_search_store #(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  sss_pkg::t_in_item     i_item,
    output logic                  empty,
    input  logic                  pop,
    output sss_pkg::t_out_item    o_item,
    input  logic                  i_cfg_we,
    input  logic [4:0]            i_cfg_data
);

    logic [4:0]          r_array_length;
    logic                cmd_empty;
    logic                cmd_take;
    sss_pkg::t_in_item   cmd_item;
    logic                res_full;
    logic                res_valid;
    sss_pkg::t_out_item  res_item;

    // hold the configured length; reset to full depth of the spec
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_length <= 5'd16;
        end else if (i_cfg_we) begin
            r_array_length <= i_cfg_data;
        end
    end

    // front: accept and buffer command transactions
    sss_cmd_queue u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_pop   (cmd_take),
        .o_empty (cmd_empty),
        .o_item  (cmd_item)
    );

    // back: execute one command at a time against the store
    sss_engine #(.DEPTH(DEPTH)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_array_length (r_array_length),
        .i_cmd_valid    (!cmd_empty),
        .i_cmd          (cmd_item),
        .o_cmd_take     (cmd_take),
        .i_out_busy     (res_full),
        .o_out_valid    (res_valid),
        .o_out          (res_item)
    );

    // result queue: hold finished transactions until popped
    sss_out_queue u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_item)
    );

endmodule
